[rtl/dll_pkg.sv]
// Shared types and constants of the doubly linked list manager.
package dll_pkg;

   localparam int NODES_DEF = 32;
   localparam int MODE_W    = 3;
   localparam int ID_W      = 5;
   localparam int ID_SPAN   = 2 ** ID_W;
   localparam int POS_W     = 6;
   localparam int CNT_OUT_W = 6;

   localparam logic [MODE_W-1:0] MODE_ADD_HEAD = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD_TAIL = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DELETE   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_POSITION = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SUCC     = 3'd5;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ID_W-1:0]   node_id;
      logic [ID_W-1:0]   anchor_node;
      logic [POS_W-1:0]  position;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]      result_node;
      logic                 found;
      logic [CNT_OUT_W-1:0] item_count;
      logic                 is_empty;
   } rsp_type;

endpackage

[rtl/dll_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module dll_ram import dll_pkg::*; #(
   parameter int WIDTH = ID_W + 1,
   parameter int DEPTH = NODES_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/doubly_linked_list_manager.sv]
// Top level of the doubly linked list manager: link memories, sequencer, result register.
//
// The block keeps an ordered list of distinct node numbers in two link RAMs (next and prev,
// one entry per node, read data registered) plus head, tail, count and a membership bit per
// node held in flip-flops. Issue a transaction by raising start while busy is low; the
// transaction is taken at that clock edge. Exactly one result follows each transaction: it
// sits on rsp_data for one cycle with rsp_strobe high, and the receiver cannot stall it, so
// capture it then. Adds run through apply and finish; insert after through read, apply and
// finish, or as an add at the tail if the anchor is the tail; delete and successor through
// read and apply. A position lookup from two up to the count walks the next links from the
// head; position one answers from the head register, and a position of zero or past the
// count, rejected operations and unused modes answer from idle. Busy drops in the result
// cycle, so a new transaction can be taken while the result is shown. Each position step
// costs one read of the next-link RAM, which is what bounds the walk. Add and insert touch
// a node and its neighbor, which share one write port per RAM, so their writes are split
// over apply and finish; delete bridges its two neighbors with one write to each RAM in
// apply. One transaction runs at a time, so no read ever meets a pending write to the same
// entry. No clearing pass: link entries are only read for nodes that are in the list.
module doubly_linked_list_manager import dll_pkg::*; #(
   parameter int NODES = NODES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   // Node numbers are ID_W bits wide, so at most ID_SPAN nodes can ever be addressed.
   localparam int SLOTS = (NODES < ID_SPAN) ? NODES : ID_SPAN;
   localparam int IW    = $clog2(SLOTS);
   localparam int LW    = IW + 1;
   localparam int CW    = $clog2(SLOTS + 1);

   // Link format: top bit marks "no neighbor", low bits hold the node index.
   localparam logic [LW-1:0] LINK_NONE = {1'b1, {IW{1'b0}}};

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_READ   = 6'b000010,
      ST_APPLY  = 6'b000100,
      ST_FINISH = 6'b001000,
      ST_WALK   = 6'b010000,
      ST_STEP   = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [MODE_W-1:0] op_ff, op_in;
   logic [IW-1:0]     n_ff, n_in;
   logic [IW-1:0]     a_ff, a_in;
   logic [LW-1:0]     link_ff, link_in;
   logic [IW-1:0]     cur_ff, cur_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic [LW-1:0]     head_ff, head_in;
   logic [LW-1:0]     tail_ff, tail_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [SLOTS-1:0]  member_ff, member_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;

   // Link RAM ports.
   logic          nx_we, pv_we;
   logic [IW-1:0] nx_waddr, pv_waddr, nx_raddr;
   logic [LW-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;

   // Request decode.
   logic [IW-1:0] req_idx, anc_idx;
   logic          n_ok, a_ok, n_member, a_member, pos_ok;

   // Result selection.
   logic          respond;
   logic          res_found;
   logic [IW-1:0] res_idx;

   dll_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_next_ram (
      .clock   (clock),
      .wr_en   (nx_we),
      .wr_addr (nx_waddr),
      .wr_data (nx_wdata),
      .rd_addr (nx_raddr),
      .rd_data (nx_rdata)
   );

   dll_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (pv_we),
      .wr_addr (pv_waddr),
      .wr_data (pv_wdata),
      .rd_addr (n_ff),
      .rd_data (pv_rdata)
   );

   assign req_idx  = req_data.node_id[IW-1:0];
   assign anc_idx  = req_data.anchor_node[IW-1:0];
   assign n_ok     = int'(req_data.node_id) < SLOTS;
   assign a_ok     = int'(req_data.anchor_node) < SLOTS;
   assign n_member = n_ok && member_ff[req_idx];
   assign a_member = a_ok && member_ff[anc_idx];
   assign pos_ok   = (req_data.position != '0) &&
                     (req_data.position <= POS_W'(count_ff));

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      n_in          = n_ff;
      a_in          = a_ff;
      link_in       = link_ff;
      cur_in        = cur_ff;
      rem_in        = rem_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      member_in     = member_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      respond       = 1'b0;
      res_found     = 1'b0;
      res_idx       = '0;
      nx_we         = 1'b0;
      nx_waddr      = n_ff;
      nx_wdata      = LINK_NONE;
      pv_we         = 1'b0;
      pv_waddr      = n_ff;
      pv_wdata      = LINK_NONE;
      nx_raddr      = n_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in  = req_data.mode;
               n_in   = req_idx;
               a_in   = anc_idx;
               cur_in = head_ff[IW-1:0];
               rem_in = CW'(req_data.position - POS_W'(1));
               case (req_data.mode) inside
                  MODE_ADD_HEAD, MODE_ADD_TAIL: begin
                     if (n_ok && !n_member) state_in = ST_APPLY;
                     else respond = 1'b1;
                  end
                  MODE_INSERT: begin
                     if (n_ok && !n_member && a_member) begin
                        // Anchor at the tail: append, no neighbor link to read.
                        if (tail_ff == {1'b0, anc_idx}) begin
                           op_in    = MODE_ADD_TAIL;
                           state_in = ST_APPLY;
                        end else begin
                           state_in = ST_READ;
                        end
                     end else begin
                        respond = 1'b1;
                     end
                  end
                  MODE_DELETE, MODE_SUCC: begin
                     if (n_member) state_in = ST_READ;
                     else respond = 1'b1;
                  end
                  MODE_POSITION: begin
                     if (pos_ok && req_data.position == POS_W'(1)) begin
                        respond   = 1'b1;
                        res_found = 1'b1;
                        res_idx   = head_ff[IW-1:0];
                     end else if (pos_ok) begin
                        state_in = ST_WALK;
                     end else begin
                        respond = 1'b1;
                     end
                  end
                  default: respond = 1'b1;
               endcase
            end
         end

         ST_READ: begin
            nx_raddr = (op_ff == MODE_INSERT) ? a_ff : n_ff;
            state_in = ST_APPLY;
         end

         ST_APPLY: begin
            case (op_ff)
               MODE_ADD_HEAD: begin
                  nx_we   = 1'b1;
                  nx_wdata = head_ff;
                  pv_we   = 1'b1;
                  link_in = head_ff;
                  head_in = {1'b0, n_ff};
                  if (head_ff[IW]) tail_in = {1'b0, n_ff};
                  member_in[n_ff] = 1'b1;
                  count_in = count_ff + CW'(1);
                  state_in = ST_FINISH;
               end
               MODE_ADD_TAIL: begin
                  pv_we    = 1'b1;
                  pv_wdata = tail_ff;
                  nx_we    = 1'b1;
                  link_in  = tail_ff;
                  tail_in  = {1'b0, n_ff};
                  if (tail_ff[IW]) head_in = {1'b0, n_ff};
                  member_in[n_ff] = 1'b1;
                  count_in = count_ff + CW'(1);
                  state_in = ST_FINISH;
               end
               MODE_INSERT: begin
                  // nx_rdata holds the anchor's old successor.
                  nx_we    = 1'b1;
                  nx_wdata = nx_rdata;
                  pv_we    = 1'b1;
                  pv_wdata = {1'b0, a_ff};
                  link_in  = nx_rdata;
                  member_in[n_ff] = 1'b1;
                  count_in = count_ff + CW'(1);
                  state_in = ST_FINISH;
               end
               MODE_DELETE: begin
                  // Bridge the neighbors; an end node moves head or tail instead.
                  if (!pv_rdata[IW]) begin
                     nx_we    = 1'b1;
                     nx_waddr = pv_rdata[IW-1:0];
                     nx_wdata = nx_rdata;
                  end else begin
                     head_in = nx_rdata;
                  end
                  if (!nx_rdata[IW]) begin
                     pv_we    = 1'b1;
                     pv_waddr = nx_rdata[IW-1:0];
                     pv_wdata = pv_rdata;
                  end else begin
                     tail_in = pv_rdata;
                  end
                  member_in[n_ff] = 1'b0;
                  count_in = count_ff - CW'(1);
                  respond  = 1'b1;
               end
               MODE_SUCC: begin
                  res_found = !nx_rdata[IW];
                  res_idx   = nx_rdata[IW-1:0];
                  respond   = 1'b1;
               end
               default: respond = 1'b1;
            endcase
         end

         ST_FINISH: begin
            case (op_ff)
               MODE_ADD_HEAD: begin
                  if (!link_ff[IW]) begin
                     pv_we    = 1'b1;
                     pv_waddr = link_ff[IW-1:0];
                     pv_wdata = {1'b0, n_ff};
                  end
               end
               MODE_ADD_TAIL: begin
                  if (!link_ff[IW]) begin
                     nx_we    = 1'b1;
                     nx_waddr = link_ff[IW-1:0];
                     nx_wdata = {1'b0, n_ff};
                  end
               end
               MODE_INSERT: begin
                  pv_we    = 1'b1;
                  pv_waddr = link_ff[IW-1:0];
                  pv_wdata = {1'b0, n_ff};
                  nx_we    = 1'b1;
                  nx_waddr = a_ff;
                  nx_wdata = {1'b0, n_ff};
               end
               default: ;
            endcase
            respond = 1'b1;
         end

         ST_WALK: begin
            nx_raddr = cur_ff;
            state_in = ST_STEP;
         end

         ST_STEP: begin
            // Follow the link straight from the read register, one hop a cycle.
            if (rem_ff == CW'(1)) begin
               respond   = 1'b1;
               res_found = 1'b1;
               res_idx   = nx_rdata[IW-1:0];
            end else begin
               nx_raddr = nx_rdata[IW-1:0];
               rem_in   = rem_ff - CW'(1);
            end
         end

         default: state_in = ST_IDLE;
      endcase

      if (respond) begin
         rsp_strobe_in      = 1'b1;
         rsp_in.result_node = res_found ? ID_W'(res_idx) : '0;
         rsp_in.found       = res_found;
         rsp_in.item_count  = CNT_OUT_W'(count_in);
         rsp_in.is_empty    = (count_in == '0);
         state_in           = ST_IDLE;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= LINK_NONE;
         tail_ff       <= LINK_NONE;
         count_ff      <= '0;
         member_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         member_ff     <= member_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Operands and result payload.
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      n_ff    <= n_in;
      a_ff    <= a_in;
      link_ff <= link_in;
      cur_ff  <= cur_in;
      rem_ff  <= rem_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

[rtl/dll_check.sv]
// Port-level checker for the doubly linked list manager, bound to the top level.
module dll_check import dll_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input req_type req_data,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // Every taken transaction either keeps the block busy or answers at once.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_strobe)
      else $error("transaction taken but no work and no result followed");

   // Busy ends only with a result.
   a_busy_ends_with_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_strobe)
      else $error("busy dropped without a result");

   // A miss carries node zero.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.found |-> rsp_data.result_node == '0)
      else $error("result node not zero on a miss");

   // Position zero is never found and answers in the next cycle.
   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.mode == MODE_POSITION && req_data.position == '0
      |=> rsp_strobe && !rsp_data.found)
      else $error("position zero not answered as a miss");

   // Empty flag agrees with the count.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.is_empty == (rsp_data.item_count == '0))
      else $error("empty flag disagrees with count");

endmodule

bind doubly_linked_list_manager dll_check u_dll_check (.*);
